@@ hdl/fpb_pkg.sv @@
package fpb_pkg;

  localparam int DEF_CAPACITY      = 8;
  localparam int DEF_PAYLOAD_WIDTH = 32;
  localparam int KEY_WIDTH         = 16;
  localparam int FILL_WIDTH        = 4;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CMP,
    ST_APPEND,
    ST_POP
  } state_t;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic empty_error;
  } res_flags_t;

endpackage

@@ hdl/fpb_ram.sv @@
module fpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fpb_seq.sv @@
module fpb_seq #(
  parameter int CAPACITY      = fpb_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_WIDTH = fpb_pkg::DEF_PAYLOAD_WIDTH,
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       operation,
  input  logic [fpb_pkg::KEY_WIDTH-1:0]    record_number,
  input  logic [PAYLOAD_WIDTH-1:0]         payload_in,
  // storage ports
  output logic                             key_we,
  output logic                             pay_we,
  output logic [SW-1:0]                    waddr,
  output logic [fpb_pkg::KEY_WIDTH-1:0]    key_wdata,
  output logic [PAYLOAD_WIDTH-1:0]         pay_wdata,
  output logic [SW-1:0]                    raddr,
  input  logic [fpb_pkg::KEY_WIDTH-1:0]    key_rdata,
  input  logic [PAYLOAD_WIDTH-1:0]         pay_rdata,
  // result
  output logic                             res_valid,
  output fpb_pkg::res_flags_t              res_flags,
  output logic [PAYLOAD_WIDTH-1:0]         res_payload,
  output logic [fpb_pkg::KEY_WIDTH-1:0]    res_ev_number,
  output logic [PAYLOAD_WIDTH-1:0]         res_ev_payload,
  output logic [CW-1:0]                    res_count
);

  fpb_pkg::state_t state, state_next;
  fpb_pkg::op_t    op, op_next;
  logic [fpb_pkg::KEY_WIDTH-1:0] key, key_next;
  logic [PAYLOAD_WIDTH-1:0]      pay, pay_next;
  logic [SW-1:0]                 oldest, oldest_next;
  logic [CW-1:0]                 count, count_next;
  logic [CW-1:0]                 probe, probe_next;
  logic [fpb_pkg::KEY_WIDTH-1:0] ev_key, ev_key_next;
  logic [PAYLOAD_WIDTH-1:0]      ev_pay, ev_pay_next;
  logic                          full;
  logic [CW:0]                   probe_inc;

  function automatic logic [SW-1:0] ring(input logic [SW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[SW-1:0];
  endfunction

  assign full      = (count == CW'(CAPACITY));
  assign probe_inc = (CW+1)'(probe) + (CW+1)'(1);
  assign busy      = (state != fpb_pkg::ST_IDLE);
  assign res_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fpb_pkg::ST_IDLE;
      oldest <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    pay    <= pay_next;
    probe  <= probe_next;
    ev_key <= ev_key_next;
    ev_pay <= ev_pay_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    key_next       = key;
    pay_next       = pay;
    oldest_next    = oldest;
    count_next     = count;
    probe_next     = probe;
    ev_key_next    = ev_key;
    ev_pay_next    = ev_pay;
    key_we         = 1'b0;
    pay_we         = 1'b0;
    waddr          = ring(oldest, probe);
    key_wdata      = key;
    pay_wdata      = pay;
    raddr          = oldest;
    res_valid      = 1'b0;
    res_flags      = '0;
    res_payload    = '0;
    res_ev_number  = '0;
    res_ev_payload = '0;

    case (state)
      fpb_pkg::ST_IDLE: begin
        if (start) begin
          op_next    = fpb_pkg::op_t'(operation);
          key_next   = record_number;
          pay_next   = payload_in;
          state_next = fpb_pkg::ST_DISPATCH;
        end
      end

      fpb_pkg::ST_DISPATCH: begin
        probe_next = '0;
        case (op)
          fpb_pkg::OP_PUSH, fpb_pkg::OP_SEARCH: begin
            if (count == '0) begin
              if (op == fpb_pkg::OP_PUSH) begin
                state_next = fpb_pkg::ST_APPEND;
              end else begin
                res_valid  = 1'b1;
                state_next = fpb_pkg::ST_IDLE;
              end
            end else begin
              // read of the oldest slot is issued here
              state_next = fpb_pkg::ST_CMP;
            end
          end
          fpb_pkg::OP_POP: begin
            if (count == '0) begin
              res_valid             = 1'b1;
              res_flags.empty_error = 1'b1;
              state_next            = fpb_pkg::ST_IDLE;
            end else begin
              state_next = fpb_pkg::ST_POP;
            end
          end
          default: begin
            count_next  = '0;
            oldest_next = '0;
            res_valid   = 1'b1;
            state_next  = fpb_pkg::ST_IDLE;
          end
        endcase
      end

      fpb_pkg::ST_CMP: begin
        // data for probe is on the read port; fetch the next one meanwhile
        raddr = ring(oldest, probe_inc[CW-1:0]);
        if (probe == '0) begin
          ev_key_next = key_rdata;
          ev_pay_next = pay_rdata;
        end
        if (key_rdata == key) begin
          res_valid     = 1'b1;
          res_flags.hit = 1'b1;
          state_next    = fpb_pkg::ST_IDLE;
          if (op == fpb_pkg::OP_PUSH) begin
            pay_we = 1'b1;
            waddr  = ring(oldest, probe);
          end else begin
            res_payload = pay_rdata;
          end
        end else if (probe_inc == (CW+1)'(count)) begin
          if (op == fpb_pkg::OP_PUSH) begin
            state_next = fpb_pkg::ST_APPEND;
          end else begin
            res_valid  = 1'b1;
            state_next = fpb_pkg::ST_IDLE;
          end
        end else begin
          probe_next = probe_inc[CW-1:0];
        end
      end

      fpb_pkg::ST_APPEND: begin
        key_we     = 1'b1;
        pay_we     = 1'b1;
        res_valid  = 1'b1;
        state_next = fpb_pkg::ST_IDLE;
        if (full) begin
          // overwrite the oldest slot, it becomes the newest
          waddr             = oldest;
          oldest_next       = ring(oldest, CW'(1));
          res_flags.evicted = 1'b1;
          res_ev_number     = ev_key;
          res_ev_payload    = ev_pay;
        end else begin
          waddr      = ring(oldest, count);
          count_next = count + CW'(1);
        end
      end

      fpb_pkg::ST_POP: begin
        res_valid     = 1'b1;
        res_payload   = pay_rdata;
        res_ev_number = key_rdata;
        oldest_next   = ring(oldest, CW'(1));
        count_next    = count - CW'(1);
        state_next    = fpb_pkg::ST_IDLE;
      end

      default: begin
        state_next = fpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/fifo_page_buffer_with_lookup_core.sv @@
// Channel   Handshake           Ports
// command   start / busy        operation, record_number, payload_in
// result    done (one cycle)    hit, payload_out, evicted, evicted_number,
//                               evicted_payload, empty_error, fill_count
//
// A command transaction is taken when start is high and busy is low.
// The result strobe done is registered from the last sequencer state: DISPATCH for
// clear or an empty pop or search, POP for pop, CMP or APPEND for push and search:
// the key memory is read one slot per cycle, oldest first, through one comparator.
// busy drops in the same cycle that done rises, so the next command may overlap it.
// Synchronous reset empties the buffer; the receiver cannot stall results.
module fifo_page_buffer_with_lookup_core #(
  parameter int CAPACITY      = fpb_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_WIDTH = fpb_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation,
  input  logic [fpb_pkg::KEY_WIDTH-1:0]       record_number,
  input  logic [PAYLOAD_WIDTH-1:0]            payload_in,
  output logic                                done,
  output logic                                hit,
  output logic [PAYLOAD_WIDTH-1:0]            payload_out,
  output logic                                evicted,
  output logic [fpb_pkg::KEY_WIDTH-1:0]       evicted_number,
  output logic [PAYLOAD_WIDTH-1:0]            evicted_payload,
  output logic                                empty_error,
  output logic [fpb_pkg::FILL_WIDTH-1:0]      fill_count
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                          key_we;
  logic                          pay_we;
  logic [SW-1:0]                 waddr;
  logic [SW-1:0]                 raddr;
  logic [fpb_pkg::KEY_WIDTH-1:0] key_wdata;
  logic [fpb_pkg::KEY_WIDTH-1:0] key_rdata;
  logic [PAYLOAD_WIDTH-1:0]      pay_wdata;
  logic [PAYLOAD_WIDTH-1:0]      pay_rdata;
  logic                          res_valid;
  fpb_pkg::res_flags_t           res_flags;
  logic [PAYLOAD_WIDTH-1:0]      res_payload;
  logic [fpb_pkg::KEY_WIDTH-1:0] res_ev_number;
  logic [PAYLOAD_WIDTH-1:0]      res_ev_payload;
  logic [CW-1:0]                 res_count;
  logic [CW+fpb_pkg::FILL_WIDTH-1:0] count_ext;

  fpb_seq #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .record_number  (record_number),
    .payload_in     (payload_in),
    .key_we         (key_we),
    .pay_we         (pay_we),
    .waddr          (waddr),
    .key_wdata      (key_wdata),
    .pay_wdata      (pay_wdata),
    .raddr          (raddr),
    .key_rdata      (key_rdata),
    .pay_rdata      (pay_rdata),
    .res_valid      (res_valid),
    .res_flags      (res_flags),
    .res_payload    (res_payload),
    .res_ev_number  (res_ev_number),
    .res_ev_payload (res_ev_payload),
    .res_count      (res_count)
  );

  fpb_ram #(
    .WIDTH (fpb_pkg::KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  fpb_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (waddr),
    .wdata (pay_wdata),
    .raddr (raddr),
    .rdata (pay_rdata)
  );

  assign count_ext = {{fpb_pkg::FILL_WIDTH{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  // hold the result for its single strobe cycle
  always_ff @(posedge clk) begin
    hit             <= res_flags.hit;
    evicted         <= res_flags.evicted;
    empty_error     <= res_flags.empty_error;
    payload_out     <= res_payload;
    evicted_number  <= res_ev_number;
    evicted_payload <= res_ev_payload;
    fill_count      <= count_ext[fpb_pkg::FILL_WIDTH-1:0];
  end

endmodule
